// File: design/olist_pkg.sv
// Shared types, codes and widths for the ordered list engine.
package olist_pkg;

  localparam int DEF_MAX_ENTRIES = 16;

  localparam int KIND_W     = 3;
  localparam int VAL_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int LEN_W      = 5;
  localparam int S_TDATA_W  = 72;
  localparam int M_TDATA_W  = 40;
  localparam int M_PAD_W    = M_TDATA_W - STATUS_W - VAL_W - LEN_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_INSERT     = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_POP_FRONT  = 3'd4,
    KIND_DELETE     = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SEARCH,
    CMD_SHR_INIT,
    CMD_SHR,
    CMD_PUT,
    CMD_SHL_INIT,
    CMD_SHL,
    CMD_DROP,
    CMD_FINISH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              empty;
    logic              found;
    logic              exhausted;
    logic              shr_done;
    logic              shl_done;
    logic              out_free;
  } dp_sts_t;

endpackage

// File: design/olist_ram.sv
// Generic single-write, single-read RAM with registered read data.
module olist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/olist_ctrl.sv
// Controller state machine: sequences search, shift and result steps.
module olist_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output olist_pkg::dp_cmd_t cmd,
  input  olist_pkg::dp_sts_t sts
);
  import olist_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH,
    S_SHR_INIT,
    S_SHR,
    S_PUT,
    S_SHL_INIT,
    S_SHL,
    S_DROP,
    S_DONE
  } state_t;

  state_t  state;
  status_t st;

  assign in_ready   = (state == S_IDLE);

  always_comb begin
    cmd.status = st;
    unique case (state)
      S_IDLE:     cmd.op = in_valid ? CMD_LOAD : CMD_NONE;
      S_DECIDE:   cmd.op = CMD_NONE;
      S_SEARCH:   cmd.op = CMD_SEARCH;
      S_SHR_INIT: cmd.op = CMD_SHR_INIT;
      S_SHR:      cmd.op = CMD_SHR;
      S_PUT:      cmd.op = CMD_PUT;
      S_SHL_INIT: cmd.op = CMD_SHL_INIT;
      S_SHL:      cmd.op = CMD_SHL;
      S_DROP:     cmd.op = CMD_DROP;
      S_DONE:     cmd.op = sts.out_free ? CMD_FINISH : CMD_NONE;
      default:    cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st    <= ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECIDE;
            st    <= ST_OK;
          end
        end
        S_DECIDE: begin
          unique case (sts.kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
              if (sts.full) begin
                st    <= ST_FULL;
                state <= S_DONE;
              end else begin
                state <= S_SHR_INIT;
              end
            end
            KIND_INSERT: begin
              if (sts.full) begin
                st    <= ST_FULL;
                state <= S_DONE;
              end else begin
                state <= S_SEARCH;
              end
            end
            KIND_POP_BACK, KIND_POP_FRONT: begin
              if (sts.empty) begin
                st    <= ST_EMPTY;
                state <= S_DONE;
              end else begin
                state <= S_SHL_INIT;
              end
            end
            KIND_DELETE: begin
              if (sts.empty) begin
                st    <= ST_EMPTY;
                state <= S_DONE;
              end else begin
                state <= S_SEARCH;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_SEARCH: begin
          if (sts.found) begin
            state <= (sts.kind == KIND_INSERT) ? S_SHR_INIT : S_SHL_INIT;
          end else if (sts.exhausted) begin
            st    <= ST_NOTFOUND;
            state <= S_DONE;
          end
        end
        S_SHR_INIT: state <= S_SHR;
        S_SHR: begin
          if (sts.shr_done) begin
            state <= S_PUT;
          end
        end
        S_PUT:      state <= S_DONE;
        S_SHL_INIT: state <= S_SHL;
        S_SHL: begin
          if (sts.shl_done) begin
            state <= S_DROP;
          end
        end
        S_DROP:     state <= S_DONE;
        S_DONE: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/olist_dp.sv
// Datapath: item registers, entry RAM, walk pointers and result register.
module olist_dp #(
  parameter int MAX_ENTRIES = olist_pkg::DEF_MAX_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic        [olist_pkg::KIND_W-1:0] in_kind,
  input  logic signed [olist_pkg::VAL_W-1:0]  in_value,
  input  logic signed [olist_pkg::VAL_W-1:0]  in_key,
  input  olist_pkg::dp_cmd_t                  cmd,
  output olist_pkg::dp_sts_t                  sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output olist_pkg::status_t                  out_status,
  output logic signed [olist_pkg::VAL_W-1:0]  out_removed,
  output logic        [olist_pkg::LEN_W-1:0]  out_length
);
  import olist_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);

  logic        [KIND_W-1:0] kind_q;
  logic signed [VAL_W-1:0]  value_q;
  logic signed [VAL_W-1:0]  key_q;
  logic        [VAL_W-1:0]  removed;
  logic        [CW-1:0]     count;
  logic        [CW-1:0]     ptr;
  logic        [CW-1:0]     pos;
  logic        [CW-1:0]     lag_ptr;
  logic                     lag_vld;

  logic [CW-1:0]    ptr_inc, ptr_dec, lag_up, lag_dn, pos_init;
  logic             more_up, more_dn, match;
  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [VAL_W-1:0] wr_data, rd_data;

  olist_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_ENTRIES)
  ) u_entries (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign ptr_inc = ptr + 1'b1;
  assign ptr_dec = ptr - 1'b1;
  assign lag_up  = lag_ptr + 1'b1;
  assign lag_dn  = lag_ptr - 1'b1;
  assign more_up = ptr < count;
  assign more_dn = ptr > pos;
  assign match   = lag_vld && (rd_data == $unsigned(key_q));

  always_comb begin
    unique case (kind_q)
      KIND_PUSH_BACK:            pos_init = count;
      KIND_POP_BACK:             pos_init = count - 1'b1;
      KIND_INSERT, KIND_DELETE:  pos_init = pos;
      default:                   pos_init = '0;
    endcase
  end

  assign sts.kind      = kind_q;
  assign sts.full      = (count == CW'(MAX_ENTRIES));
  assign sts.empty     = (count == '0);
  assign sts.found     = match;
  assign sts.exhausted = !match && !more_up;
  assign sts.shr_done  = !lag_vld && (ptr == pos);
  assign sts.shl_done  = !lag_vld && !more_up;
  assign sts.out_free  = !out_valid || out_ready;

  // Shifts read one entry per beat and write the one read the beat before.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = pos[AW-1:0];
    wr_data = rd_data;
    unique case (cmd.op)
      CMD_SEARCH: begin
        rd_en = more_up;
      end
      CMD_SHR: begin
        rd_en   = more_dn;
        rd_addr = ptr_dec[AW-1:0];
        wr_en   = lag_vld;
        wr_addr = lag_up[AW-1:0];
      end
      CMD_SHL: begin
        rd_en   = more_up;
        wr_en   = lag_vld && (lag_ptr != pos);
        wr_addr = lag_dn[AW-1:0];
      end
      CMD_PUT: begin
        wr_en   = 1'b1;
        wr_data = value_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      lag_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // load a new result, else drop the one just taken
      if (cmd.op == CMD_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        CMD_LOAD:                   lag_vld <= 1'b0;
        CMD_SEARCH, CMD_SHL:        lag_vld <= more_up;
        CMD_SHR:                    lag_vld <= more_dn;
        CMD_SHR_INIT, CMD_SHL_INIT: lag_vld <= 1'b0;
        CMD_PUT:                    count   <= count + 1'b1;
        CMD_DROP:                   count   <= count - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LOAD: begin
        kind_q  <= in_kind;
        value_q <= in_value;
        key_q   <= in_key;
        removed <= '0;
        ptr     <= '0;
      end
      CMD_SEARCH: begin
        if (more_up) begin
          ptr     <= ptr_inc;
          lag_ptr <= ptr;
        end
        if (match) begin
          pos <= lag_ptr;
        end
      end
      CMD_SHR_INIT: begin
        pos <= pos_init;
        ptr <= count;
      end
      CMD_SHR: begin
        if (more_dn) begin
          ptr     <= ptr_dec;
          lag_ptr <= ptr_dec;
        end
      end
      CMD_SHL_INIT: begin
        pos <= pos_init;
        ptr <= pos_init;
      end
      CMD_SHL: begin
        if (more_up) begin
          ptr     <= ptr_inc;
          lag_ptr <= ptr;
        end
        // capture the entry being taken out instead of moving it
        if (lag_vld && (lag_ptr == pos)) begin
          removed <= rd_data;
        end
      end
      CMD_FINISH: begin
        out_status  <= cmd.status;
        out_removed <= removed;
        out_length  <= LEN_W'(count);
      end
      default: ;
    endcase
  end

endmodule

// File: design/ordered_list_engine_core.sv
// Sequence: an unused kind or a refused request goes from decode straight to the result beat,
// a push back shifts and then puts, and an insert or delete searches and then shifts.
// Throughput: one request at a time; a search or shift step is one RAM read per cycle, and a
// result beat held by m_tready stalls the next finish.
// A finished result waits in the output register while the next beat is accepted.
// Reset (rst, synchronous) empties the list and drops any pending result.
module ordered_list_engine_core #(
  parameter int MAX_ENTRIES = olist_pkg::DEF_MAX_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [olist_pkg::S_TDATA_W-1:0]   s_tdata,  // value[31:0], key[63:32], zero pad
  input  logic [olist_pkg::KIND_W-1:0]      s_tuser,  // kind[2:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [olist_pkg::M_TDATA_W-1:0]   m_tdata   // status, removed_value, length, pad
);
  import olist_pkg::*;

  dp_cmd_t                  cmd;
  dp_sts_t                  sts;
  status_t                  out_status;
  logic signed [VAL_W-1:0]  out_removed;
  logic        [LEN_W-1:0]  out_length;

  olist_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .cmd     (cmd),
    .sts     (sts)
  );

  olist_dp #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_kind    (s_tuser),
    .in_value   (s_tdata[VAL_W-1:0]),
    .in_key     (s_tdata[2*VAL_W-1:VAL_W]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_removed(out_removed),
    .out_length (out_length)
  );

  assign m_tdata = {{M_PAD_W{1'b0}}, out_length, out_removed, out_status};

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("new beat accepted while a request is in progress");

  a_full_length: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_status == ST_FULL) |-> out_length == LEN_W'(MAX_ENTRIES))
    else $error("full status with a list that is not full");

  a_empty_length: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_status == ST_EMPTY) |-> out_length == '0)
    else $error("empty status with a non-empty list");

  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_status != ST_OK) |-> out_removed == '0)
    else $error("removed value reported on a failed request");

endmodule
